### sv/msa_pkg.sv
// Shared types and constants for the mesh router switch allocator.
package msa_pkg;

  localparam int NUM_PORTS = 5;
  localparam int ID_W      = 4;
  localparam int SEL_W     = 3;

  typedef logic [NUM_PORTS-1:0] port_mask_t;
  typedef logic [ID_W-1:0]      node_id_t;

  // Output port codes as seen on the select fields.
  typedef enum logic [SEL_W-1:0] {
    SEL_NONE  = 3'd0,
    SEL_LOCAL = 3'd1,
    SEL_NORTH = 3'd2,
    SEL_EAST  = 3'd3,
    SEL_SOUTH = 3'd4,
    SEL_WEST  = 3'd5
  } sel_code_t;

  // What one routing lane hands to the merge stage.
  typedef struct packed {
    logic      active;
    logic      tail;
    sel_code_t code;
  } lane_req_t;

  // One-hot output bit for a port code; code c owns output bit c-1.
  function automatic port_mask_t code_onehot(input sel_code_t code);
    port_mask_t m;
    m = '0;
    case (code)
      SEL_LOCAL: m = 5'b00001;
      SEL_NORTH: m = 5'b00010;
      SEL_EAST:  m = 5'b00100;
      SEL_SOUTH: m = 5'b01000;
      SEL_WEST:  m = 5'b10000;
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

### sv/msa_req_if.sv
// Request channel: one router cycle worth of input state per word.
interface msa_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] dest_in0;
  logic [3:0] dest_in1;
  logic [3:0] dest_in2;
  logic [3:0] dest_in3;
  logic [3:0] dest_in4;
  logic [4:0] empty_mask;
  logic [4:0] tail_mask;
  logic [4:0] release_mask;

  modport source (
    output valid, dest_in0, dest_in1, dest_in2, dest_in3, dest_in4,
           empty_mask, tail_mask, release_mask,
    input  ready
  );
  modport sink (
    input  valid, dest_in0, dest_in1, dest_in2, dest_in3, dest_in4,
           empty_mask, tail_mask, release_mask,
    output ready
  );
endinterface

### sv/msa_res_if.sv
// Result channel: grants and port selects per word.
interface msa_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] grant_mask;
  logic [2:0] port_sel0;
  logic [2:0] port_sel1;
  logic [2:0] port_sel2;
  logic [2:0] port_sel3;
  logic [2:0] port_sel4;

  modport source (
    output valid, grant_mask, port_sel0, port_sel1, port_sel2, port_sel3, port_sel4,
    input  ready
  );
  modport sink (
    input  valid, grant_mask, port_sel0, port_sel1, port_sel2, port_sel3, port_sel4,
    output ready
  );
endinterface

### sv/msa_route_lane.sv
// One routing lane: picks the output port for one input's destination.
module msa_route_lane (
  input  msa_pkg::node_id_t  router_id,
  input  msa_pkg::node_id_t  dest,
  output msa_pkg::sel_code_t code
);
  import msa_pkg::*;

  // Bits are compared in the order 1, 3, 2, 0; the first mismatch decides.
  always_comb begin
    if (router_id[1] != dest[1]) begin
      code = router_id[1] ? SEL_WEST : SEL_EAST;
    end else if (router_id[3] != dest[3]) begin
      code = router_id[3] ? SEL_NORTH : SEL_SOUTH;
    end else if (router_id[2] != dest[2]) begin
      code = router_id[2] ? SEL_NORTH : SEL_SOUTH;
    end else if (router_id[0] != dest[0]) begin
      code = router_id[0] ? SEL_WEST : SEL_EAST;
    end else begin
      code = SEL_LOCAL;
    end
  end

endmodule

### sv/msa_grant_merge.sv
// Merge stage: fixed-priority grant over the lanes and the allocation state.
module msa_grant_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  msa_pkg::lane_req_t  lanes [msa_pkg::NUM_PORTS],
  input  msa_pkg::port_mask_t release_mask,
  output msa_pkg::port_mask_t grant_mask,
  output msa_pkg::sel_code_t  sel [msa_pkg::NUM_PORTS]
);
  import msa_pkg::*;

  port_mask_t free_outputs, free_outputs_next;
  port_mask_t input_connected, input_connected_next;
  port_mask_t output_reserved, output_reserved_next;
  port_mask_t grant_next;
  sel_code_t  select_codes [NUM_PORTS];
  sel_code_t  select_codes_next [NUM_PORTS];

  // Inputs are served lowest index first; each grant removes its output
  // from the free set seen by the inputs after it.
  always_comb begin
    port_mask_t obit;
    obit                 = '0;
    free_outputs_next    = free_outputs | release_mask;
    input_connected_next = input_connected;
    output_reserved_next = output_reserved;
    grant_next           = '0;
    select_codes_next    = select_codes;
    for (int i = 0; i < NUM_PORTS; i++) begin
      obit = code_onehot(lanes[i].code);
      if (lanes[i].active && ((free_outputs_next & obit) != '0) &&
          (input_connected_next[i] || ((output_reserved_next & obit) == '0))) begin
        grant_next[i]        = 1'b1;
        select_codes_next[i] = lanes[i].code;
        free_outputs_next    = free_outputs_next & ~obit;
        if (lanes[i].tail) begin
          input_connected_next[i] = 1'b0;
          output_reserved_next    = output_reserved_next & ~obit;
        end else begin
          input_connected_next[i] = 1'b1;
          output_reserved_next    = output_reserved_next | obit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_outputs    <= '1;
      input_connected <= '0;
      output_reserved <= '0;
      grant_mask      <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        select_codes[i] <= SEL_NONE;
      end
    end else if (advance) begin
      free_outputs    <= free_outputs_next;
      input_connected <= input_connected_next;
      output_reserved <= output_reserved_next;
      grant_mask      <= grant_next;
      select_codes    <= select_codes_next;
    end
  end

  assign sel = select_codes;

endmodule

### sv/mesh_router_switch_allocator_unit.sv
// Top level of the mesh router switch allocator.
//
// Each request word is one router cycle: the destination of the flit at
// each of the five inputs, which inputs are empty, which carry tail flits,
// and which outputs report themselves free. Each accepted request produces
// exactly one result word holding the grant mask and the port select code
// of every input (held from its last grant when not granted).
// Five routing lanes compute the output port of every input side by side;
// the merge stage then grants them in fixed priority, input 0 first, and
// updates the free, connected and reserved masks.
// Throughput is one word per cycle while the receiver does not stall;
// the lane-plus-merge path into the state registers is combinational.
// The result sits in an output register; the request side stays ready
// while that register is empty or being drained in the same cycle, so a
// stalled receiver holds the result and back-pressures the request side.
// Reset clears the router id to zero, marks all outputs free, drops all
// connections and reservations and sets every select code to none.
// The user must write router_id through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module mesh_router_switch_allocator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  msa_pkg::node_id_t   cfg_wdata,
  msa_req_if.sink             in_ch,
  msa_res_if.source           out_ch
);
  import msa_pkg::*;

  node_id_t   router_id;
  logic       out_valid;
  logic       accept;
  node_id_t   dest [NUM_PORTS];
  lane_req_t  lanes [NUM_PORTS];
  sel_code_t  codes [NUM_PORTS];
  sel_code_t  sel [NUM_PORTS];
  port_mask_t grant_mask;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      router_id <= '0;
    end else if (cfg_we) begin
      router_id <= cfg_wdata;
    end
  end

  // Output register handshake: take a new word whenever the held result
  // is absent or leaving this cycle.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign dest[0] = in_ch.dest_in0;
  assign dest[1] = in_ch.dest_in1;
  assign dest[2] = in_ch.dest_in2;
  assign dest[3] = in_ch.dest_in3;
  assign dest[4] = in_ch.dest_in4;

  // One routing lane per input.
  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
    msa_route_lane u_lane (
      .router_id (router_id),
      .dest      (dest[g]),
      .code      (codes[g])
    );
    assign lanes[g].active = !in_ch.empty_mask[g];
    assign lanes[g].tail   = in_ch.tail_mask[g];
    assign lanes[g].code   = codes[g];
  end

  msa_grant_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .lanes        (lanes),
    .release_mask (in_ch.release_mask),
    .grant_mask   (grant_mask),
    .sel          (sel)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.grant_mask = grant_mask;
  assign out_ch.port_sel0  = sel[0];
  assign out_ch.port_sel1  = sel[1];
  assign out_ch.port_sel2  = sel[2];
  assign out_ch.port_sel3  = sel[3];
  assign out_ch.port_sel4  = sel[4];

endmodule

### tb/mesh_router_switch_allocator_unit_tb.sv
// Self-checking testbench for the mesh router switch allocator top level.
`timescale 1ns / 100ps

module mesh_router_switch_allocator_unit_tb;
  import msa_pkg::*;

  // Generous cycle budget. The slowest correct run stays well below it:
  // about 1700 words, each waiting out a long receiver stall and a sender gap.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 275;
  localparam int NUM_PHASES  = 6;

  // One request word: one router cycle of input state.
  typedef struct packed {
    node_id_t [NUM_PORTS-1:0] dest;
    port_mask_t               empty;
    port_mask_t               tail;
    port_mask_t               rel;
  } alloc_req_t;

  // One result word: grants and the select code of every input.
  typedef struct packed {
    port_mask_t                         grant;
    logic [NUM_PORTS-1:0][SEL_W-1:0]    sel;
  } alloc_res_t;

  // One row of the directed table: either a router id write or a request word,
  // the latter optionally carrying a result that can be typed in by hand.
  typedef struct {
    bit         is_cfg;
    node_id_t   cfg_val;
    alloc_req_t req;
    bit         known;
    alloc_res_t res;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     cfg_we;
  node_id_t cfg_wdata;

  msa_req_if req_bus ();
  msa_res_if res_bus ();

  mesh_router_switch_allocator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_bus),
    .out_ch    (res_bus)
  );

  // Side band that travels with each request word: when set, the monitor
  // queues the hand-typed result instead of the predicted one.
  logic       req_known;
  alloc_res_t req_known_res;

  // Shadow copy of the allocator state, kept by the monitor.
  node_id_t                        shadow_id;
  port_mask_t                      shadow_free;
  port_mask_t                      shadow_conn;
  port_mask_t                      shadow_resv;
  logic [NUM_PORTS-1:0][SEL_W-1:0] shadow_sel;

  alloc_res_t grants_due[$];
  stim_row_t  plan[$];
  int         fail_count;
  int         cycle_count;
  int         burst_left;
  bit         req_up;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Dimension-order route: compare id bits in the order 1, 3, 2, 0 and turn
  // toward the first differing bit; all equal means the flit is for us.
  function automatic sel_code_t route_port(node_id_t id, node_id_t dst);
    if (id[1] != dst[1]) return id[1] ? SEL_WEST : SEL_EAST;
    if (id[3] != dst[3]) return id[3] ? SEL_NORTH : SEL_SOUTH;
    if (id[2] != dst[2]) return id[2] ? SEL_NORTH : SEL_SOUTH;
    if (id[0] != dst[0]) return id[0] ? SEL_WEST : SEL_EAST;
    return SEL_LOCAL;
  endfunction

  // Advances the shadow state by one router cycle and returns its result.
  // Released outputs become free first, then inputs are served 0 to 4.
  function automatic alloc_res_t predict_grants(alloc_req_t w);
    alloc_res_t r;
    sel_code_t  code;
    port_mask_t obit;
    bit         ok;
    r.grant = '0;
    shadow_free = shadow_free | w.rel;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (!w.empty[i]) begin
        code = route_port(shadow_id, w.dest[i]);
        obit = port_mask_t'(1) << (int'(code) - 1);
        ok = (shadow_free & obit) != '0;
        // A head flit may not break into a worm that still owns the output.
        if (!shadow_conn[i] && (shadow_resv & obit) != '0) ok = 1'b0;
        if (ok) begin
          r.grant[i] = 1'b1;
          shadow_sel[i] = code;
          shadow_free &= ~obit;
          shadow_conn[i] = 1'b1;
          shadow_resv |= obit;
          // The tail ends the worm now; the output stays busy until released.
          if (w.tail[i]) begin
            shadow_conn[i] = 1'b0;
            shadow_resv &= ~obit;
          end
        end
      end
    end
    r.sel = shadow_sel;
    return r;
  endfunction

  function automatic void add_cfg(node_id_t v);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    plan.push_back(row);
  endfunction

  function automatic void add_req(node_id_t d0, node_id_t d1, node_id_t d2, node_id_t d3,
                                  node_id_t d4, port_mask_t e, port_mask_t t, port_mask_t r);
    stim_row_t row;
    row = '{default: '0};
    row.req.dest[0] = d0;
    row.req.dest[1] = d1;
    row.req.dest[2] = d2;
    row.req.dest[3] = d3;
    row.req.dest[4] = d4;
    row.req.empty = e;
    row.req.tail = t;
    row.req.rel = r;
    plan.push_back(row);
  endfunction

  function automatic void add_known(node_id_t d0, node_id_t d1, node_id_t d2, node_id_t d3,
                                    node_id_t d4, port_mask_t e, port_mask_t t, port_mask_t r,
                                    port_mask_t g, sel_code_t s0, sel_code_t s1, sel_code_t s2,
                                    sel_code_t s3, sel_code_t s4);
    int last;
    add_req(d0, d1, d2, d3, d4, e, t, r);
    last = plan.size() - 1;
    plan[last].known = 1'b1;
    plan[last].res.grant = g;
    plan[last].res.sel[0] = s0;
    plan[last].res.sel[1] = s1;
    plan[last].res.sel[2] = s2;
    plan[last].res.sel[3] = s3;
    plan[last].res.sel[4] = s4;
  endfunction

  function automatic void report_mismatch(string what, alloc_res_t want, alloc_res_t got);
    fail_count++;
    if (fail_count <= 10)
      $display({"%s: expected grant %b sel %0d %0d %0d %0d %0d, ",
                "got grant %b sel %0d %0d %0d %0d %0d"},
               what, want.grant, want.sel[0], want.sel[1], want.sel[2], want.sel[3],
               want.sel[4], got.grant, got.sel[0], got.sel[1], got.sel[2], got.sel[3],
               got.sel[4]);
  endfunction

  // Monitor: retires result words against the oldest expectation, then
  // predicts the word accepted at this edge. Every signal read here is the
  // value from before the edge, since all drivers use nonblocking updates.
  always @(posedge clk) begin : monitor
    alloc_req_t w;
    alloc_res_t got;
    alloc_res_t want;
    bit         bad;
    if (rst) begin
      shadow_id   = '0;
      shadow_free = '1;
      shadow_conn = '0;
      shadow_resv = '0;
      shadow_sel  = '0;
    end else begin
      if (cfg_we) shadow_id = cfg_wdata;
      if (res_bus.valid && res_bus.ready) begin
        got.grant  = res_bus.grant_mask;
        got.sel[0] = res_bus.port_sel0;
        got.sel[1] = res_bus.port_sel1;
        got.sel[2] = res_bus.port_sel2;
        got.sel[3] = res_bus.port_sel3;
        got.sel[4] = res_bus.port_sel4;
        if (grants_due.size() == 0) begin
          report_mismatch("unexpected result word", '0, got);
        end else begin
          want = grants_due.pop_front();
          bad = (got.grant !== want.grant);
          for (int i = 0; i < NUM_PORTS; i++)
            if (got.sel[i] !== want.sel[i]) bad = 1'b1;
          if (bad) report_mismatch("result mismatch", want, got);
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        w.dest[0] = req_bus.dest_in0;
        w.dest[1] = req_bus.dest_in1;
        w.dest[2] = req_bus.dest_in2;
        w.dest[3] = req_bus.dest_in3;
        w.dest[4] = req_bus.dest_in4;
        w.empty   = req_bus.empty_mask;
        w.tail    = req_bus.tail_mask;
        w.rel     = req_bus.release_mask;
        // The shadow state always advances; a typed result only replaces
        // what is queued for this word.
        want = predict_grants(w);
        if (req_known) want = req_known_res;
        grants_due.push_back(want);
      end
    end
  end

  // Receiver: picks a stall mode for a random stretch of cycles, ranging
  // from always ready to long stalls with rare single-cycle openings.
  initial begin : receiver
    int mode;
    int left;
    res_bus.ready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(4, 40);
      end
      left--;
      case (mode)
        0: begin
          res_bus.ready <= 1'b1;
        end
        1: begin
          res_bus.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          res_bus.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          res_bus.ready <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one word and holds it until accepted. Words go out in bursts; at
  // the end of a burst valid drops for a random gap before the next word, so
  // valid is never lowered and raised within the same time step.
  task automatic send_word(alloc_req_t w, bit known, alloc_res_t kres);
    req_bus.valid        <= 1'b1;
    req_bus.dest_in0     <= w.dest[0];
    req_bus.dest_in1     <= w.dest[1];
    req_bus.dest_in2     <= w.dest[2];
    req_bus.dest_in3     <= w.dest[3];
    req_bus.dest_in4     <= w.dest[4];
    req_bus.empty_mask   <= w.empty;
    req_bus.tail_mask    <= w.tail;
    req_bus.release_mask <= w.rel;
    req_known            <= known;
    req_known_res        <= kres;
    req_up = 1'b1;
    do @(posedge clk); while (!req_bus.ready);
    burst_left--;
    if (burst_left <= 0) begin
      req_bus.valid <= 1'b0;
      req_up = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
  endtask

  // Stops offering words and waits until every queued result has arrived.
  // The first edge lets the monitor queue the word accepted just before.
  task automatic drain_results();
    if (req_up) begin
      req_bus.valid <= 1'b0;
      req_up = 1'b0;
    end
    @(posedge clk);
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  // Every word yields exactly one result, so once the queue is empty the
  // block is idle and the router id may be changed.
  task automatic set_router_id(node_id_t v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    alloc_req_t w;
    node_id_t   worm_dest [NUM_PORTS];
    node_id_t   phase_id;
    int         empty_pct;
    int         tail_pct;
    int         rel_pct;

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_bus.valid        <= 1'b0;
    req_bus.dest_in0     <= '0;
    req_bus.dest_in1     <= '0;
    req_bus.dest_in2     <= '0;
    req_bus.dest_in3     <= '0;
    req_bus.dest_in4     <= '0;
    req_bus.empty_mask   <= '0;
    req_bus.tail_mask    <= '0;
    req_bus.release_mask <= '0;
    req_known            <= 1'b0;
    req_known_res        <= '0;
    req_up      = 1'b0;
    fail_count  = 0;
    cycle_count = 0;
    burst_left  = $urandom_range(1, 20);

    // Directed table. Router id is zero out of reset.
    // Nothing is offered at all: no grant, every select still none.
    add_known(0, 0, 0, 0, 0, 5'b11111, 5'b00000, 5'b00000,
              5'b00000, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE);
    // A head flit for this node at input 0 takes the local output.
    add_known(0, 0, 0, 0, 0, 5'b11110, 5'b00000, 5'b00000,
              5'b00001, SEL_LOCAL, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE);
    // Releases alone grant nothing and the select of input 0 is held.
    add_known(0, 0, 0, 0, 0, 5'b11111, 5'b00000, 5'b11111,
              5'b00000, SEL_LOCAL, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE);
    // Input 1 runs into the worm that input 0 still holds on local.
    add_req(0, 0, 0, 0, 0, 5'b11101, 5'b00000, 5'b00000);
    // The tail of input 0 ends the worm; local stays busy for input 1.
    add_req(0, 0, 0, 0, 0, 5'b11100, 5'b00001, 5'b00000);
    // Local is reported free and no longer reserved, so input 1 gets it.
    add_req(0, 0, 0, 0, 0, 5'b11101, 5'b00000, 5'b00001);
    // Flits for east, south, south, east and local; contention on south and east.
    add_req(2, 8, 4, 1, 0, 5'b00000, 5'b11111, 5'b11111);
    add_req(15, 15, 15, 15, 15, 5'b00000, 5'b00000, 5'b11111);
    add_req(0, 0, 0, 0, 0, 5'b00000, 5'b11111, 5'b11111);
    add_cfg(15);
    add_req(13, 7, 11, 14, 15, 5'b00000, 5'b00000, 5'b11111);
    add_req(13, 7, 11, 14, 15, 5'b00000, 5'b11111, 5'b11111);
    add_req(0, 0, 0, 0, 0, 5'b00000, 5'b00000, 5'b00000);
    add_req(0, 0, 0, 0, 0, 5'b11111, 5'b11111, 5'b11111);
    add_cfg(5);
    add_req(7, 13, 1, 4, 5, 5'b00000, 5'b11111, 5'b11111);
    add_req(7, 13, 1, 4, 5, 5'b10101, 5'b00000, 5'b00000);
    add_req(7, 13, 1, 4, 5, 5'b01010, 5'b11111, 5'b11111);
    add_cfg(10);
    add_req(8, 2, 14, 11, 10, 5'b00000, 5'b00000, 5'b11111);
    add_req(15, 15, 15, 15, 15, 5'b00000, 5'b11111, 5'b00000);
    add_req(15, 15, 15, 15, 15, 5'b00000, 5'b11111, 5'b11111);
    add_req(10, 10, 10, 10, 10, 5'b00000, 5'b10101, 5'b11111);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        set_router_id(plan[k].cfg_val);
      end else begin
        send_word(plan[k].req, plan[k].known, plan[k].res);
      end
    end

    // Random phases. Most words model worms: each input keeps a destination
    // for a while, so head, body and tail flits of one packet follow each
    // other. The rest is noise with every field drawn freely.
    foreach (worm_dest[i]) worm_dest[i] = node_id_t'($urandom_range(0, 15));
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_id = 15;
        1: phase_id = 0;
        2: phase_id = 9;
        3: phase_id = 6;
        default: phase_id = node_id_t'($urandom_range(0, 15));
      endcase
      set_router_id(phase_id);
      empty_pct = $urandom_range(5, 50);
      tail_pct  = $urandom_range(5, 40);
      rel_pct   = $urandom_range(10, 70);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          foreach (w.dest[i]) w.dest[i] = node_id_t'($urandom_range(0, 15));
          w.empty = port_mask_t'($urandom_range(0, 31));
          w.tail  = port_mask_t'($urandom_range(0, 31));
          w.rel   = port_mask_t'($urandom_range(0, 31));
        end else begin
          for (int i = 0; i < NUM_PORTS; i++) begin
            if ($urandom_range(0, 7) == 0) worm_dest[i] = node_id_t'($urandom_range(0, 15));
            w.dest[i]  = worm_dest[i];
            w.empty[i] = ($urandom_range(0, 99) < empty_pct);
            w.tail[i]  = ($urandom_range(0, 99) < tail_pct);
            w.rel[i]   = ($urandom_range(0, 99) < rel_pct);
          end
        end
        send_word(w, 1'b0, '0);
        // Now and then hold back until the receiver has taken everything.
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    // Let the last results arrive, then keep watching for strays.
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && grants_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
sv/msa_pkg.sv
sv/msa_req_if.sv
sv/msa_res_if.sv
sv/msa_route_lane.sv
sv/msa_grant_merge.sv
sv/mesh_router_switch_allocator_unit.sv
tb/mesh_router_switch_allocator_unit_tb.sv
